// ----- src/eeb_pkg.sv -----
// ----------------------------------------------------------------------------
// eeb_pkg: shared types and constants for the I2C EEPROM byte master
// Item structs, configuration set, bus phase codes and the per-request
// operation sequence.
// ----------------------------------------------------------------------------
package eeb_pkg;

  localparam int MEM_ADDR_W = 13;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;
  localparam logic [1:0] REQ_PROBE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_HOLD   = 2'd2;

  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
  localparam logic [15:0] WRITE_HOLD_RST  = 16'd5000;
  localparam logic [7:0]  READ_HOLD_RST   = 8'd50;

  localparam logic [7:0] CTRL_WRITE = 8'hA0;
  localparam logic [7:0] CTRL_READ  = 8'hA1;
  localparam logic [7:0] CTRL_PROBE = 8'hA2;

  typedef struct packed {
    logic [1:0]            req_type;
    logic [MEM_ADDR_W-1:0] mem_address;
    logic [7:0]            write_byte;
    logic                  sda_sample;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       write_protect;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_byte;
    logic       ack_error;
    logic       large_device;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  ack_timeout_ticks;
    logic [15:0] write_hold_ticks;
    logic [7:0]  read_hold_ticks;
  } cfg_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START0,
    PH_START1,
    PH_START2,
    PH_START3,
    PH_TXLOW,
    PH_TXHIGH,
    PH_ACKLOW,
    PH_ACKHIGH,
    PH_RXLOW,
    PH_RXHIGH,
    PH_NACKLOW,
    PH_NACKHIGH,
    PH_STOP0,
    PH_STOP1,
    PH_STOP2,
    PH_HOLD
  } phase_t;

  typedef enum logic [1:0] {
    OP_END,
    OP_START,
    OP_TX,
    OP_RX
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } op_item_t;

  function automatic op_item_t op_at(input logic [2:0] step, input logic [1:0] kind,
                                     input logic [MEM_ADDR_W-1:0] addr,
                                     input logic [7:0] data, input logic is_large);
    op_item_t   r;
    logic [2:0] s;
    logic [7:0] first;
    r.op   = OP_END;
    r.data = 8'd0;
    s      = step - {2'b00, is_large};
    first  = is_large ? CTRL_WRITE : (CTRL_WRITE | {4'b0000, addr[10:8], 1'b0});
    if (step == 3'd0) begin
      r.op = OP_START;
    end else if (kind == REQ_PROBE) begin
      if (step == 3'd1) begin
        r.op   = OP_TX;
        r.data = CTRL_PROBE;
      end
    end else if (step == 3'd1) begin
      r.op   = OP_TX;
      r.data = first;
    end else if (is_large && step == 3'd2) begin
      r.op   = OP_TX;
      r.data = {3'b000, addr[12:8]};
    end else if (s == 3'd2) begin
      r.op   = OP_TX;
      r.data = addr[7:0];
    end else if (kind == REQ_WRITE) begin
      if (s == 3'd3) begin
        r.op   = OP_TX;
        r.data = data;
      end
    end else begin
      if (s == 3'd3) begin
        r.op = OP_START;
      end else if (s == 3'd4) begin
        r.op   = OP_TX;
        r.data = CTRL_READ;
      end else if (s == 3'd5) begin
        r.op = OP_RX;
      end
    end
    return r;
  endfunction

endpackage

// ----- src/eeb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// eeb_cfg_regs: configuration registers
// Timeout and hold-time registers written through the configuration channel.
// ----------------------------------------------------------------------------
module eeb_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [eeb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [eeb_pkg::CFG_DATA_W-1:0]      cfg_data,
  output eeb_pkg::cfg_t                       cfg
);

  eeb_pkg::cfg_t cfg_r;
  eeb_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        eeb_pkg::CFG_ACK_TIMEOUT: cfg_nxt.ack_timeout_ticks = cfg_data[7:0];
        eeb_pkg::CFG_WRITE_HOLD:  cfg_nxt.write_hold_ticks  = cfg_data;
        eeb_pkg::CFG_READ_HOLD:   cfg_nxt.read_hold_ticks   = cfg_data[7:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_timeout_ticks <= eeb_pkg::ACK_TIMEOUT_RST;
      cfg_r.write_hold_ticks  <= eeb_pkg::WRITE_HOLD_RST;
      cfg_r.read_hold_ticks   <= eeb_pkg::READ_HOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- src/eeb_engine.sv -----
// ----------------------------------------------------------------------------
// eeb_engine: bus phase engine
// Holds the transaction state and advances it by one bus phase per item,
// producing the line levels and status for that item.
// ----------------------------------------------------------------------------
module eeb_engine #(
  parameter int ADDR_BITS = 13
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  eeb_pkg::in_item_t   item,
  input  eeb_pkg::cfg_t       cfg,
  output eeb_pkg::out_item_t  result
);

  localparam int MaskBits = (ADDR_BITS < eeb_pkg::MEM_ADDR_W) ? ADDR_BITS
                                                               : eeb_pkg::MEM_ADDR_W;
  localparam logic [eeb_pkg::MEM_ADDR_W-1:0] ADDR_MASK =
    eeb_pkg::MEM_ADDR_W'((33'd1 << MaskBits) - 33'd1);

  eeb_pkg::phase_t                 phase_r, phase_nxt, phase_cur;
  logic [3:0]                      bit_cnt_r, bit_cnt_nxt;
  logic [7:0]                      shift_r, shift_nxt;
  logic [2:0]                      step_r, step_nxt;
  logic [15:0]                     timer_r, timer_nxt, timer_inc, hold_sel;
  logic                            large_r, large_nxt;
  logic [1:0]                      kind_r, kind_nxt;
  logic [eeb_pkg::MEM_ADDR_W-1:0]  addr_r, addr_nxt;
  logic [7:0]                      data_r, data_nxt;
  logic                            err_r, err_nxt;
  logic [7:0]                      rxbyte_r, rxbyte_nxt;
  eeb_pkg::op_item_t               nop;
  logic                            do_next;
  logic                            scl, pull, done, wp;

  always_comb begin
    phase_nxt   = phase_r;
    bit_cnt_nxt = bit_cnt_r;
    shift_nxt   = shift_r;
    step_nxt    = step_r;
    timer_nxt   = timer_r;
    large_nxt   = large_r;
    kind_nxt    = kind_r;
    addr_nxt    = addr_r;
    data_nxt    = data_r;
    err_nxt     = err_r;
    rxbyte_nxt  = rxbyte_r;
    scl         = 1'b1;
    pull        = 1'b0;
    done        = 1'b0;
    wp          = 1'b1;
    do_next     = 1'b0;

    if (phase_r == eeb_pkg::PH_IDLE && item.req_type != eeb_pkg::REQ_TICK) begin
      kind_nxt    = item.req_type;
      addr_nxt    = item.mem_address & ADDR_MASK;
      data_nxt    = item.write_byte;
      err_nxt     = 1'b0;
      step_nxt    = 3'd0;
      bit_cnt_nxt = 4'd0;
      timer_nxt   = 16'd0;
      phase_nxt   = eeb_pkg::PH_START0;
    end

    phase_cur = phase_nxt;
    timer_inc = timer_nxt + 16'd1;
    hold_sel  = (kind_nxt == eeb_pkg::REQ_WRITE) ? cfg.write_hold_ticks :
                (kind_nxt == eeb_pkg::REQ_READ)  ? {8'd0, cfg.read_hold_ticks} : 16'd0;
    nop       = eeb_pkg::op_at(step_nxt + 3'd1, kind_nxt, addr_nxt, data_nxt, large_nxt);

    if (phase_cur != eeb_pkg::PH_IDLE && kind_nxt == eeb_pkg::REQ_WRITE &&
        phase_cur != eeb_pkg::PH_HOLD) begin
      wp = 1'b0;
    end

    unique case (phase_cur)
      eeb_pkg::PH_IDLE: begin
        phase_nxt = eeb_pkg::PH_IDLE;
      end
      eeb_pkg::PH_START0: begin
        scl       = 1'b0;
        phase_nxt = eeb_pkg::PH_START1;
      end
      eeb_pkg::PH_START1: begin
        phase_nxt = eeb_pkg::PH_START2;
      end
      eeb_pkg::PH_START2: begin
        pull      = 1'b1;
        phase_nxt = eeb_pkg::PH_START3;
      end
      eeb_pkg::PH_START3: begin
        scl     = 1'b0;
        pull    = 1'b1;
        do_next = 1'b1;
      end
      eeb_pkg::PH_TXLOW: begin
        scl       = 1'b0;
        pull      = ~shift_nxt[7];
        phase_nxt = eeb_pkg::PH_TXHIGH;
      end
      eeb_pkg::PH_TXHIGH: begin
        pull        = ~shift_nxt[7];
        shift_nxt   = {shift_nxt[6:0], 1'b0};
        bit_cnt_nxt = bit_cnt_nxt + 4'd1;
        if (bit_cnt_nxt >= 4'd8) begin
          timer_nxt = 16'd0;
          phase_nxt = eeb_pkg::PH_ACKLOW;
        end else begin
          phase_nxt = eeb_pkg::PH_TXLOW;
        end
      end
      eeb_pkg::PH_ACKLOW: begin
        scl       = 1'b0;
        phase_nxt = eeb_pkg::PH_ACKHIGH;
      end
      eeb_pkg::PH_ACKHIGH: begin
        if (!item.sda_sample) begin
          if (kind_nxt == eeb_pkg::REQ_PROBE) begin
            large_nxt = 1'b0;
          end
          do_next = 1'b1;
        end else begin
          timer_nxt = timer_inc;
          if (timer_inc > {8'd0, cfg.ack_timeout_ticks}) begin
            if (kind_nxt == eeb_pkg::REQ_PROBE) begin
              large_nxt = 1'b1;
            end else begin
              err_nxt = 1'b1;
            end
            phase_nxt = eeb_pkg::PH_STOP0;
          end
        end
      end
      eeb_pkg::PH_RXLOW: begin
        scl       = 1'b0;
        phase_nxt = eeb_pkg::PH_RXHIGH;
      end
      eeb_pkg::PH_RXHIGH: begin
        shift_nxt   = {shift_nxt[6:0], item.sda_sample};
        bit_cnt_nxt = bit_cnt_nxt + 4'd1;
        phase_nxt   = (bit_cnt_nxt >= 4'd8) ? eeb_pkg::PH_NACKLOW : eeb_pkg::PH_RXLOW;
      end
      eeb_pkg::PH_NACKLOW: begin
        scl       = 1'b0;
        phase_nxt = eeb_pkg::PH_NACKHIGH;
      end
      eeb_pkg::PH_NACKHIGH: begin
        rxbyte_nxt = shift_nxt;
        do_next    = 1'b1;
      end
      eeb_pkg::PH_STOP0: begin
        scl       = 1'b0;
        pull      = 1'b1;
        phase_nxt = eeb_pkg::PH_STOP1;
      end
      eeb_pkg::PH_STOP1: begin
        pull      = 1'b1;
        phase_nxt = eeb_pkg::PH_STOP2;
      end
      eeb_pkg::PH_STOP2: begin
        timer_nxt = 16'd0;
        if (kind_nxt == eeb_pkg::REQ_PROBE || hold_sel == 16'd0) begin
          done      = 1'b1;
          phase_nxt = eeb_pkg::PH_IDLE;
        end else begin
          phase_nxt = eeb_pkg::PH_HOLD;
        end
      end
      eeb_pkg::PH_HOLD: begin
        timer_nxt = timer_inc;
        if (timer_inc >= hold_sel) begin
          done      = 1'b1;
          phase_nxt = eeb_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = eeb_pkg::PH_IDLE;
      end
    endcase

    if (do_next) begin
      step_nxt    = step_nxt + 3'd1;
      bit_cnt_nxt = 4'd0;
      unique case (nop.op)
        eeb_pkg::OP_START: phase_nxt = eeb_pkg::PH_START0;
        eeb_pkg::OP_TX: begin
          shift_nxt = nop.data;
          phase_nxt = eeb_pkg::PH_TXLOW;
        end
        eeb_pkg::OP_RX: begin
          shift_nxt = 8'd0;
          phase_nxt = eeb_pkg::PH_RXLOW;
        end
        default: phase_nxt = eeb_pkg::PH_STOP0;
      endcase
    end
  end

  always_comb begin
    result.scl_level     = scl;
    result.sda_pull_low  = pull;
    result.write_protect = wp;
    result.busy_res      = (phase_nxt != eeb_pkg::PH_IDLE);
    result.done_res      = done;
    result.read_byte     = rxbyte_nxt;
    result.ack_error     = err_nxt;
    result.large_device  = large_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= eeb_pkg::PH_IDLE;
      bit_cnt_r <= 4'd0;
      shift_r   <= 8'd0;
      step_r    <= 3'd0;
      timer_r   <= 16'd0;
      large_r   <= 1'b0;
      kind_r    <= eeb_pkg::REQ_TICK;
      addr_r    <= '0;
      data_r    <= 8'd0;
      err_r     <= 1'b0;
      rxbyte_r  <= 8'd0;
    end else if (step_en) begin
      phase_r   <= phase_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      shift_r   <= shift_nxt;
      step_r    <= step_nxt;
      timer_r   <= timer_nxt;
      large_r   <= large_nxt;
      kind_r    <= kind_nxt;
      addr_r    <= addr_nxt;
      data_r    <= data_nxt;
      err_r     <= err_nxt;
      rxbyte_r  <= rxbyte_nxt;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && result.done_res |-> !result.busy_res)
    else $error("done with busy still set");

  a_wp_only_write: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !result.write_protect |-> kind_nxt == eeb_pkg::REQ_WRITE)
    else $error("write-protect lowered outside a write");

  a_bit_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_cnt_r <= 4'd8)
    else $error("bit counter out of range");

  a_idle_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> $stable(phase_r) && $stable(timer_r))
    else $error("state moved without an item");

endmodule

// ----- src/i2c_eeprom_byte_master.sv -----
// ----------------------------------------------------------------------------
// i2c_eeprom_byte_master: bit-level I2C master for a 24Cxx EEPROM
// Byte read, byte write and device probe, one bus phase per tick item.
// ----------------------------------------------------------------------------
// Each input item is one bus tick and yields exactly one result item carrying
// the SCL and SDA drive levels, write-protect and status for that tick. The
// block takes one item per clock unless a result waits in the output register
// untaken; an accepted item passes the input register, the phase engine and
// the output register. Requests arriving while busy_res is high are ignored.
// The user must write configuration registers (index 0 ack timeout, 1 write
// hold, 2 read hold) only while no item is in flight; nothing enforces this.
module i2c_eeprom_byte_master #(
  parameter int ADDR_BITS = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  eeb_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output eeb_pkg::out_item_t                out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [eeb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [eeb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  eeb_pkg::cfg_t      cfg;
  eeb_pkg::in_item_t  stage_item_r;
  logic               stage_valid_r, stage_valid_nxt;
  eeb_pkg::out_item_t out_item_r;
  logic               out_valid_r, out_valid_nxt;
  eeb_pkg::out_item_t result;
  logic               fire;
  logic               in_take;

  eeb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  eeb_engine #(
    .ADDR_BITS (ADDR_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fire),
    .item    (stage_item_r),
    .cfg     (cfg),
    .result  (result)
  );

  assign fire      = stage_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !stage_valid_r || fire;
  assign in_take   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    stage_valid_nxt = in_take ? 1'b1 : (fire ? 1'b0 : stage_valid_r);
    out_valid_nxt   = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      stage_item_r <= in_item;
    end
    if (fire) begin
      out_item_r <= result;
    end
  end

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> stage_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room downstream");

  a_fire_sets_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed item did not reach the output register");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !fire)
    else $error("result overwritten before it was taken");

endmodule
